FILE: rtl/amdfs_pkg.sv
// Shared types, codes and the control store for the adjacency-matrix DFS block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package amdfs_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int VERT_W           = 6;
	localparam int CNT_W            = 7;
	localparam int CMD_W            = 2;
	localparam int WGT_W            = 15;
	localparam int VC_RESET         = 64;
	localparam logic [WGT_W-1:0] NO_EDGE_WEIGHT = 15'd32767;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRAV  = 2'd2;

	// datapath operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
	localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
	localparam logic [OP_W-1:0] OP_READ_A  = 4'd2;
	localparam logic [OP_W-1:0] OP_WRITE_A = 4'd3;
	localparam logic [OP_W-1:0] OP_WRITE_B = 4'd4;
	localparam logic [OP_W-1:0] OP_START   = 4'd5;
	localparam logic [OP_W-1:0] OP_RD_TOS  = 4'd6;
	localparam logic [OP_W-1:0] OP_CAND    = 4'd7;
	localparam logic [OP_W-1:0] OP_PUSH    = 4'd8;
	localparam logic [OP_W-1:0] OP_POP     = 4'd9;
	localparam logic [OP_W-1:0] OP_RESTORE = 4'd10;
	localparam logic [OP_W-1:0] OP_FINISH  = 4'd11;

	// next-step kinds
	localparam int NX_W = 2;
	localparam logic [NX_W-1:0] NX_SEQ      = 2'd0;
	localparam logic [NX_W-1:0] NX_GOTO     = 2'd1;
	localparam logic [NX_W-1:0] NX_BRANCH   = 2'd2;
	localparam logic [NX_W-1:0] NX_DISPATCH = 2'd3;

	// branch conditions
	localparam int CND_W = 2;
	localparam logic [CND_W-1:0] C_NEVER     = 2'd0;
	localparam logic [CND_W-1:0] C_NO_INPUT  = 2'd1;
	localparam logic [CND_W-1:0] C_CAND_ZERO = 2'd2;
	localparam logic [CND_W-1:0] C_DEPTH_ONE = 2'd3;

	// program steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] S_DISP   = 4'd1;
	localparam logic [STEP_W-1:0] S_CLR    = 4'd2;
	localparam logic [STEP_W-1:0] S_ADD_RD = 4'd3;
	localparam logic [STEP_W-1:0] S_ADD_WA = 4'd4;
	localparam logic [STEP_W-1:0] S_ADD_WB = 4'd5;
	localparam logic [STEP_W-1:0] S_START  = 4'd6;
	localparam logic [STEP_W-1:0] S_RD     = 4'd7;
	localparam logic [STEP_W-1:0] S_CAND   = 4'd8;
	localparam logic [STEP_W-1:0] S_TEST   = 4'd9;
	localparam logic [STEP_W-1:0] S_PUSH   = 4'd10;
	localparam logic [STEP_W-1:0] S_POP    = 4'd11;
	localparam logic [STEP_W-1:0] S_REST   = 4'd12;
	localparam logic [STEP_W-1:0] S_FIN    = 4'd13;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NX_W-1:0]   nx;
		logic [CND_W-1:0]  cond;
		logic              wait_out;
		logic [STEP_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            idle;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             a_ok;
		logic             b_ok;
		logic             cand_zero;
		logic             depth_one;
		logic             out_busy;
	} stat_t;

	function automatic ucw_t mk(input logic [OP_W-1:0] op, input logic [NX_W-1:0] nx,
			input logic [CND_W-1:0] cond, input logic wait_out, input logic [STEP_W-1:0] tgt);
		ucw_t w;
		w.op       = op;
		w.nx       = nx;
		w.cond     = cond;
		w.wait_out = wait_out;
		w.target   = tgt;
		return w;
	endfunction

	// control store
	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		unique case (step)
			S_IDLE:   w = mk(OP_NONE,    NX_BRANCH,   C_NO_INPUT,  1'b0, S_IDLE);
			S_DISP:   w = mk(OP_NONE,    NX_DISPATCH, C_NEVER,     1'b0, S_IDLE);
			S_CLR:    w = mk(OP_CLEAR,   NX_GOTO,     C_NEVER,     1'b0, S_IDLE);
			S_ADD_RD: w = mk(OP_READ_A,  NX_SEQ,      C_NEVER,     1'b0, S_IDLE);
			S_ADD_WA: w = mk(OP_WRITE_A, NX_SEQ,      C_NEVER,     1'b0, S_IDLE);
			S_ADD_WB: w = mk(OP_WRITE_B, NX_GOTO,     C_NEVER,     1'b0, S_IDLE);
			S_START:  w = mk(OP_START,   NX_SEQ,      C_NEVER,     1'b0, S_IDLE);
			S_RD:     w = mk(OP_RD_TOS,  NX_SEQ,      C_NEVER,     1'b0, S_IDLE);
			S_CAND:   w = mk(OP_CAND,    NX_SEQ,      C_NEVER,     1'b0, S_IDLE);
			S_TEST:   w = mk(OP_NONE,    NX_BRANCH,   C_CAND_ZERO, 1'b0, S_POP);
			S_PUSH:   w = mk(OP_PUSH,    NX_GOTO,     C_NEVER,     1'b1, S_RD);
			S_POP:    w = mk(OP_POP,     NX_BRANCH,   C_DEPTH_ONE, 1'b0, S_FIN);
			S_REST:   w = mk(OP_RESTORE, NX_GOTO,     C_NEVER,     1'b0, S_RD);
			S_FIN:    w = mk(OP_FINISH,  NX_GOTO,     C_NEVER,     1'b1, S_IDLE);
			default:  w = mk(OP_NONE,    NX_GOTO,     C_NEVER,     1'b0, S_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/amdfs_seq.sv
// Step counter and control-store sequencer for the DFS block.
// Depends on amdfs_pkg (control store, codes, ctl_t and stat_t).
`timescale 1ns / 1ps

module amdfs_seq import amdfs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output ctl_t  ctl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nx;
	logic [STEP_W-1:0] disp_tgt;
	ucw_t              ucw;
	logic              hold;
	logic              cond_hit;

	assign ucw  = ucode(step_q);
	assign hold = ucw.wait_out && stat.out_busy;

	always_comb begin
		case (ucw.cond)
			C_NO_INPUT:  cond_hit = !in_valid;
			C_CAND_ZERO: cond_hit = stat.cand_zero;
			C_DEPTH_ONE: cond_hit = stat.depth_one;
			default:     cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		unique case (stat.cmd)
			CMD_CLEAR: disp_tgt = S_CLR;
			CMD_ADD:   disp_tgt = (stat.a_ok && stat.b_ok) ? S_ADD_RD : S_IDLE;
			CMD_TRAV:  disp_tgt = stat.a_ok ? S_START : S_IDLE;
			default:   disp_tgt = S_IDLE;
		endcase
	end

	always_comb begin
		if (hold) begin
			step_nx = step_q;
		end else begin
			unique case (ucw.nx)
				NX_SEQ:      step_nx = STEP_W'(step_q + 1'b1);
				NX_GOTO:     step_nx = ucw.target;
				NX_BRANCH:   step_nx = cond_hit ? ucw.target : STEP_W'(step_q + 1'b1);
				NX_DISPATCH: step_nx = disp_tgt;
				default:     step_nx = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_nx;
		end
	end

	// suppress the step's operation while it waits on the output register
	assign ctl.op   = hold ? OP_NONE : ucw.op;
	assign ctl.idle = (step_q == S_IDLE);

endmodule

FILE: rtl/amdfs_datapath.sv
// Datapath of the DFS block: adjacency and stack memories, visited marks,
// candidate search and the output register. Depends on amdfs_pkg.
`timescale 1ns / 1ps

module amdfs_datapath import amdfs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CMD_W-1:0]  command,
	input  logic [VERT_W-1:0] vertex_a,
	input  logic [VERT_W-1:0] vertex_b,
	input  logic [WGT_W-1:0]  edge_weight,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  ctl_t              ctl,
	output stat_t             stat,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [VERT_W-1:0] visited_vertex,
	output logic              last
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);

	logic [CMD_W-1:0]        cmd_q;
	logic [VERT_W-1:0]       a_q;
	logic [VERT_W-1:0]       b_q;
	logic                    set_q;
	logic [CNT_W-1:0]        vc_q;
	logic [CNT_W-1:0]        n_act;
	logic [MAX_VERTICES-1:0] act_mask;
	logic [IW-1:0]           a_idx;
	logic [IW-1:0]           b_idx;

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] adj_rd_q;
	logic                    adj_rdv_q;
	logic [MAX_VERTICES-1:0] row_eff;
	logic [IW-1:0]           adj_raddr;
	logic                    adj_we;
	logic [IW-1:0]           adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;

	logic [IW-1:0]           stk_mem [MAX_VERTICES];
	logic [IW-1:0]           stk_rd_q;
	logic [DW-1:0]           depth_q;

	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] cand_q;
	logic [IW-1:0]           tos_q;
	logic [IW-1:0]           pend_q;
	logic [IW-1:0]           w_low;

	logic                    out_valid_q;
	logic [VERT_W-1:0]       out_vtx_q;
	logic                    out_last_q;
	logic                    emit;

	// saturate the vertex count at the array size
	assign n_act = (vc_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_q;
	assign a_idx = a_q[IW-1:0];
	assign b_idx = b_q[IW-1:0];

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			act_mask[i] = (CNT_W'(i) < n_act);
		end
	end

	// lowest set bit of the candidate word
	always_comb begin
		w_low = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand_q[i]) begin
				w_low = IW'(i);
			end
		end
	end

	assign row_eff = adj_rdv_q ? adj_rd_q : '0;

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = a_idx;
		adj_wdata = row_eff;
		case (ctl.op)
			OP_WRITE_A: begin
				adj_we    = 1'b1;
				adj_waddr = a_idx;
				adj_wdata = set_q ? (row_eff | (MAX_VERTICES'(1) << b_idx))
				                  : (row_eff & ~(MAX_VERTICES'(1) << b_idx));
			end
			OP_WRITE_B: begin
				adj_we    = 1'b1;
				adj_waddr = b_idx;
				adj_wdata = set_q ? (row_eff | (MAX_VERTICES'(1) << a_idx))
				                  : (row_eff & ~(MAX_VERTICES'(1) << a_idx));
			end
			default: ;
		endcase
	end

	always_comb begin
		case (ctl.op)
			OP_READ_A:  adj_raddr = a_idx;
			OP_WRITE_A: adj_raddr = b_idx;
			default:    adj_raddr = tos_q;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_rd_q  <= adj_mem[adj_raddr];
		adj_rdv_q <= row_vld_q[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_START) begin
			stk_mem[0] <= a_idx;
		end else if (ctl.op == OP_PUSH) begin
			stk_mem[depth_q[IW-1:0]] <= w_low;
		end
		stk_rd_q <= stk_mem[IW'(depth_q - DW'(2))];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			a_q   <= vertex_a;
			b_q   <= vertex_b;
			set_q <= (edge_weight != NO_EDGE_WEIGHT);
		end
		if (ctl.op == OP_CAND) begin
			cand_q <= row_eff & act_mask & ~visited_q;
		end
		case (ctl.op)
			OP_START: begin
				tos_q  <= a_idx;
				pend_q <= a_idx;
			end
			OP_PUSH: begin
				tos_q  <= w_low;
				pend_q <= w_low;
			end
			OP_RESTORE: tos_q <= stk_rd_q;
			default: ;
		endcase
		if (emit) begin
			out_vtx_q  <= VERT_W'(pend_q);
			out_last_q <= (ctl.op == OP_FINISH);
		end
	end

	assign emit = (ctl.op == OP_PUSH) || (ctl.op == OP_FINISH);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= CNT_W'(VC_RESET);
			row_vld_q   <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			if (ctl.op == OP_CLEAR) begin
				row_vld_q <= '0;
			end else if (adj_we) begin
				row_vld_q[adj_waddr] <= 1'b1;
			end
			case (ctl.op)
				OP_START: begin
					visited_q <= MAX_VERTICES'(1) << a_idx;
					depth_q   <= DW'(1);
				end
				OP_PUSH: begin
					visited_q <= visited_q | (MAX_VERTICES'(1) << w_low);
					depth_q   <= DW'(depth_q + 1'b1);
				end
				OP_POP: depth_q <= DW'(depth_q - 1'b1);
				default: ;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cmd       = cmd_q;
	assign stat.a_ok      = (CNT_W'(a_q) < n_act);
	assign stat.b_ok      = (CNT_W'(b_q) < n_act);
	assign stat.cand_zero = (cand_q == '0);
	assign stat.depth_one = (depth_q == DW'(1));
	assign stat.out_busy  = out_valid_q && out_stall;

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vtx_q;
	assign last           = out_last_q;

endmodule

FILE: rtl/adjacency_matrix_dfs_order_top.sv
// Clear: dispatch, then the clear step. Add edge: read row a, write row a, write row b.
// Traverse: start, then per vertex a row read, candidate scan and test; a push emits the
// vertex before it and descends, a pop and restore backtrack, and finish emits the last one.
// Commands are handled one at a time; the row scan per vertex sets the traversal rate.
// Reset (arst_n low, async): edges cleared at once by row valid bits, no sweep;
// vertex_count returns to 64; no result pending.
`timescale 1ns / 1ps

module adjacency_matrix_dfs_order_top import amdfs_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [VERT_W-1:0] vertex_a,
	input  logic [VERT_W-1:0] vertex_b,
	input  logic [WGT_W-1:0]  edge_weight,
	// vertex_count register
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VERT_W-1:0] visited_vertex,
	output logic              last
);

	ctl_t  ctl;
	stat_t stat;
	logic  accept;

	// Take a command only while the sequencer sits in its idle step; a result
	// left in the output register does not hold off the next transfer.
	assign in_stall = !ctl.idle;
	assign accept   = in_valid && !in_stall;

	// Sequencer: steps the control store, waits on the output register
	// before each emit, and dispatches on the latched command.
	amdfs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Datapath: the adjacency rows and walk stack live here. Each visited
	// vertex is held one step so the final one can carry the last flag.
	amdfs_datapath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.command        (command),
		.vertex_a       (vertex_a),
		.vertex_b       (vertex_b),
		.edge_weight    (edge_weight),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.ctl            (ctl),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.visited_vertex (visited_vertex),
		.last           (last)
	);

endmodule

FILE: rtl/amdfs_checker.sv
// Port-level checks for the DFS block, bound to its top level.
// Depends on amdfs_pkg for field widths.
`timescale 1ns / 1ps

module amdfs_checker import amdfs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [VERT_W-1:0] visited_vertex,
	input logic              last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(visited_vertex) && $stable(last))
		else $error("stalled result changed");

	// a transfer starts work: the block is busy in the next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command taken without going busy");

	// when ready for commands, any waiting result must be the final one
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && out_valid |-> last)
		else $error("idle with a non-final result pending");

endmodule

bind adjacency_matrix_dfs_order_top amdfs_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.visited_vertex (visited_vertex),
	.last           (last)
);
